@@ src/sha_pkg.sv @@
// SHA-256 shared package: payload structs, controller state enum, command/status structs,
// round constants and the initial hash value. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  word_bytes;
        logic        msg_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IN,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        WSEL_MSG,
        WSEL_ZERO,
        WSEL_LENHI,
        WSEL_LENLO
    } t_wsel;

    typedef struct packed {
        logic  push;
        t_wsel wsel;
        logic  load;
        logic  round;
        logic  add;
        logic  reinit;
        logic  cnt_add;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic [3:0] word_pos;
        logic [5:0] round_idx;
        logic [2:0] out_idx;
    } t_status;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[idx];
    endfunction

endpackage

@@ src/sha_ctrl.sv @@
// SHA-256 controller: sequences word intake, padding, 64 rounds and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_end,
    input  logic [2:0]        i_in_bytes,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sha_pkg::t_status  i_status,
    output sha_pkg::t_cmd     o_cmd
);
    import sha_pkg::*;

    t_state r_state, n_state;
    // padding must follow end of message: true once the message is closed
    logic   r_ending, n_ending;
    // set when a full final word still needs its 0x80 word
    logic   r_need_mark, n_need_mark;
    // length high word is in the buffer; this block is the last one
    logic   r_len_due, n_len_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_ending    <= 1'b0;
            r_need_mark <= 1'b0;
            r_len_due   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ending    <= n_ending;
            r_need_mark <= n_need_mark;
            r_len_due   <= n_len_due;
        end
    end

    always_comb begin
        logic full_word;
        full_word   = (i_in_bytes >= 3'd4);
        n_state     = r_state;
        n_ending    = r_ending;
        n_need_mark = r_need_mark;
        n_len_due   = r_len_due;
        o_cmd       = '0;
        o_cmd.wsel  = WSEL_MSG;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cnt_add = 1'b1;
                    o_cmd.push    = !(i_in_end && i_in_bytes == 3'd0);
                    if (i_in_end) begin
                        n_ending    = 1'b1;
                        n_need_mark = full_word;
                        if (i_in_bytes == 3'd0 || !full_word) begin
                            // word carries its own mark or is replaced by one
                            o_cmd.push  = 1'b1;
                            n_need_mark = 1'b0;
                        end
                        if (o_cmd.push && i_status.word_pos == 4'd15)
                            n_state = ST_LOAD;
                        else
                            n_state = ST_PAD;
                    end else if (i_status.word_pos == 4'd15) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (r_need_mark) begin
                    o_cmd.wsel  = WSEL_MSG;
                    n_need_mark = 1'b0;
                end else if (i_status.word_pos == 4'd14) begin
                    o_cmd.wsel = WSEL_LENHI;
                    n_len_due  = 1'b1;
                end else if (i_status.word_pos == 4'd15 && r_len_due) begin
                    o_cmd.wsel = WSEL_LENLO;
                end else begin
                    o_cmd.wsel = WSEL_ZERO;
                end
                if (i_status.word_pos == 4'd15) begin
                    n_state = ST_LOAD;
                    if (o_cmd.wsel == WSEL_LENLO)
                        n_ending = 1'b0;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_idx == 6'd63)
                    n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                // the block holding the length closes the message
                if (r_len_due) begin
                    n_len_due = 1'b0;
                    n_state   = ST_OUT;
                end else if (r_ending || r_need_mark) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IN;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.out_idx == 3'd7) begin
                        o_cmd.reinit = 1'b1;
                        n_state      = ST_IN;
                    end
                end
            end
            default: n_state = ST_IN;
        endcase
    end

endmodule

@@ src/sha_dp.sv @@
// SHA-256 datapath: block buffer, message schedule window, working variables,
// chaining value, byte counter and output index. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_in_item i_in,
    input  sha_pkg::t_cmd     i_cmd,
    output sha_pkg::t_status  o_status,
    output sha_pkg::t_out_item o_out
);
    import sha_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];
    logic [3:0]  r_pos;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;
    logic [60:0] r_cnt;
    logic [63:0] bits;
    logic [31:0] push_val;

    assign bits = {r_cnt, 3'b000};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        logic [2:0]  nb;
        logic [31:0] keep;
        nb = (i_in.word_bytes > 3'd4) ? 3'd4 : i_in.word_bytes;
        unique case (nb[1:0])
            2'd0: keep = 32'h0000_0000;
            2'd1: keep = 32'hFF00_0000;
            2'd2: keep = 32'hFFFF_0000;
            default: keep = 32'hFFFF_FF00;
        endcase
        unique case (i_cmd.wsel)
            WSEL_MSG: begin
                if (i_cmd.cnt_add && i_in.msg_end && !nb[2])
                    push_val = (i_in.msg_word & keep) | (PAD_MARK >> {nb[1:0], 3'b000});
                else if (i_cmd.cnt_add)
                    push_val = i_in.msg_word;
                else
                    push_val = PAD_MARK;
            end
            WSEL_ZERO:  push_val = '0;
            WSEL_LENHI: push_val = bits[63:32];
            default:    push_val = bits[31:0];
        endcase
    end

    logic [31:0] s0, s1, w_new, t1, t2, big0, big1, ch, maj;
    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        big1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + big1 + ch + round_k(r_rnd) + r_w[0];
        big0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = big0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push)
            r_buf[r_pos] <= push_val;
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
            for (int i = 0; i < 8; i++)  r_v[i] <= r_h[i];
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            for (int i = 1; i < 8; i++)  if (i != 4) r_v[i] <= r_v[i-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_rnd  <= '0;
            r_oidx <= '0;
            r_cnt  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            if (i_cmd.push)  r_pos <= r_pos + 4'd1;
            if (i_cmd.round) r_rnd <= r_rnd + 6'd1;
            if (i_cmd.cnt_add)
                r_cnt <= r_cnt + ((!i_in.msg_end || i_in.word_bytes > 3'd4)
                                  ? 61'd4 : 61'(i_in.word_bytes));
            if (i_cmd.add)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (i_cmd.emit) begin
                r_oidx <= r_oidx + 3'd1;
                if (i_cmd.reinit) begin
                    // last digest item: back to the initial value for the next message
                    for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                    r_cnt <= '0;
                end else begin
                    for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                    r_h[7] <= r_h[0];
                end
            end
        end
    end

    assign o_status.word_pos  = r_pos;
    assign o_status.round_idx = r_rnd;
    assign o_status.out_idx   = r_oidx;
    assign o_out.digest_word  = r_h[0];
    assign o_out.digest_index = r_oidx;
    assign o_out.digest_last  = (r_oidx == 3'd7);

endmodule

@@ src/sha256_message_hash.sv @@
// SHA-256 message hash top level: one item per cycle intake while in the input state,
// one round per cycle. Each 16-word block runs 16 pushes, a load, 64 rounds and an add;
// padding pushes the pad words plus a second block when needed; 8 digest items follow.
// No new message words are taken while the single shared round unit works on a block.
// Reset (synchronous, active low) loads the initial hash value and clears counters.
`timescale 1ns / 1ps
module sha256_message_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sha_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sha_pkg::t_out_item  o_out_data
);
    import sha_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_end   (i_in_data.msg_end),
        .i_in_bytes (i_in_data.word_bytes),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sha_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out_data)
    );

endmodule

@@ tb/sv/tb_sha256_message_hash.sv @@
// Testbench for sha256_message_hash: streams messages as word items, predicts digests
// with an in-bench SHA-256 scoreboard and checks every digest item. Depends on sha_pkg.
`timescale 1ns / 1ps

class digest_scoreboard;
    bit [31:0] hash_state [8];
    bit [31:0] blk [16];
    int unsigned word_pos;
    bit [60:0] byte_total;
    sha_pkg::t_out_item expected_q [$];
    int unsigned error_count;

    function new();
        error_count = 0;
        restart();
    endfunction

    function void restart();
        hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        word_pos = 0;
        byte_total = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] t1, t2, s0, s1;
        bit [31:0] kc [64];
        kc = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int r = 0; r < 16; r++) w[r] = blk[r];
        for (int r = 16; r < 64; r++) begin
            s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        v = hash_state;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hash_state[r] += v[r];
    endfunction

    function void push(bit [31:0] wd);
        blk[word_pos] = wd;
        word_pos = (word_pos + 1) % 16;
        if (word_pos == 0) compress();
    endfunction

    // note one accepted input item; a final item queues the eight digest items
    function void note_input(sha_pkg::t_in_item it);
        int unsigned nb;
        bit [63:0] bit_len;
        bit [31:0] keep;
        sha_pkg::t_out_item o;
        nb = it.word_bytes;
        if (nb > 4 || !it.msg_end) nb = 4;
        byte_total += nb;
        if (!it.msg_end) begin
            push(it.msg_word);
            return;
        end
        if (nb == 4) begin
            push(it.msg_word);
            push(32'h8000_0000);
        end else begin
            keep = ~(32'hffff_ffff >> (8 * nb));
            push((it.msg_word & keep) | (32'h8000_0000 >> (8 * nb)));
        end
        while (word_pos != 14) push(32'h0);
        bit_len = {byte_total, 3'b000};
        push(bit_len[63:32]);
        push(bit_len[31:0]);
        for (int i = 0; i < 8; i++) begin
            o.digest_word = hash_state[i];
            o.digest_index = 3'(i);
            o.digest_last = (i == 7);
            expected_q.push_back(o);
        end
        restart();
    endfunction

    task report(string what);
        $display("ERROR %0t: %s", $realtime, what);
        error_count++;
    endtask

    task check_result(sha_pkg::t_out_item got);
        sha_pkg::t_out_item exp;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected digest item %h", got));
            return;
        end
        exp = expected_q.pop_front();
        if (got.digest_word !== exp.digest_word)
            report($sformatf("digest_word %h, want %h", got.digest_word, exp.digest_word));
        if (got.digest_index !== exp.digest_index)
            report($sformatf("digest_index %0d, want %0d", got.digest_index,
                             exp.digest_index));
        if (got.digest_last !== exp.digest_last)
            report($sformatf("digest_last %0d, want %0d", got.digest_last, exp.digest_last));
    endtask
endclass

module tb_sha256_message_hash;
    import sha_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_data;

    digest_scoreboard sb;
    int unsigned cycle_count;
    int unsigned burst_left;
    bit stall_mode;

    sha256_message_hash DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial sb = new();

    // sample on the rising edge; checks and input notes share this ordering
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sha256_message_hash: done, errors");
            $finish;
        end
    end

    // receiver stall pattern: alternates between free-running and random stalls
    always @(negedge i_clk) begin
        if (($urandom % 64) == 0) stall_mode <= ~stall_mode;
        i_out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // one item: optional gap first, then hold valid until accepted
    task send_item(logic [31:0] wd, logic [2:0] nb, logic fin);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= '{msg_word: wd, word_bytes: nb, msg_end: fin};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input('{msg_word: wd, word_bytes: nb, msg_end: fin});
        @(negedge i_clk);
    endtask

    task send_message(int unsigned n_words, logic [2:0] last_nb);
        for (int i = 0; i < n_words; i++)
            send_item($urandom, 3'($urandom), 1'b0);
        send_item($urandom, last_nb, 1'b1);
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        cycle_count = 0;
        burst_left = 0;
        stall_mode = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, each final byte count, field extremes, block boundaries
        send_item(32'h0, 3'd0, 1'b1);
        send_item(32'hffff_ffff, 3'd1, 1'b1);
        send_item(32'hffff_ffff, 3'd2, 1'b1);
        send_item(32'h6162_63ff, 3'd3, 1'b1);
        send_item(32'hffff_ffff, 3'd4, 1'b1);
        send_item(32'hffff_ffff, 3'd7, 1'b1);
        send_item(32'h0, 3'd5, 1'b1);
        send_item(32'hffff_ffff, 3'd1, 1'b0);
        send_item(32'h0, 3'd6, 1'b1);
        drain();
        send_message(13, 3'd3);
        send_message(13, 3'd4);
        send_message(15, 3'd0);
        send_message(16, 3'd2);
        drain();

        sent = 0;
        while (sent < 340) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
            send_message(n, 3'($urandom));
            sent += n + 1;
            if ($urandom_range(0, 9) == 0) drain();
        end
        drain();
        repeat (200) @(negedge i_clk);
        if (sb.error_count == 0 && sb.expected_q.size() == 0)
            $display("tb_sha256_message_hash: done, clean");
        else
            $display("tb_sha256_message_hash: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dp.sv
src/sha256_message_hash.sv
tb/sv/tb_sha256_message_hash.sv
